FILE: rtl/disk_request_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Disk request scheduler assertion macros
// Wrappers for concurrent checks on clk_i with reset rst_ni; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef DISK_REQUEST_SCHEDULER_DEFINES_SVH
`define DISK_REQUEST_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
// plain property, sampled on clk_i, off during reset
`define DRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// same-cycle implication
`define DRS_ASSERT_IMP(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (con)) else $error(msg);
`else
`define DRS_ASSERT(lbl, prop, msg)
`define DRS_ASSERT_IMP(lbl, pre, con, msg)
`endif

`endif

FILE: rtl/dsched_pkg.sv
// ----------------------------------------------------------------------------
// dsched_pkg
// Shared types and codes of the disk request scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package dsched_pkg;

  localparam logic REQ_ARRIVAL  = 1'b0;
  localparam logic REQ_COMPLETE = 1'b1;

  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_SSTF = 2'd1;
  localparam logic [1:0] POL_LOOK = 2'd2;

  localparam int unsigned REG_POLICY = 0;

  typedef struct packed {
    logic        req_type;
    logic [15:0] req_id;
    logic [31:0] req_arrival;
    logic [15:0] req_cylinder;
    logic [31:0] req_address;
    logic [15:0] req_process;
    logic [15:0] head_cylinder;
    logic        scan_up;
  } req_t;

  typedef struct packed {
    logic        busy_res;
    logic [15:0] serve_id;
    logic [31:0] serve_arrival;
    logic [15:0] serve_cylinder;
    logic [31:0] serve_address;
    logic [15:0] serve_process;
    logic        dropped;
    logic [4:0]  pending;
  } res_t;

  // one queued request
  typedef struct packed {
    logic [15:0] id;
    logic [31:0] arrival;
    logic [15:0] cylinder;
    logic [31:0] address;
    logic [15:0] process;
  } entry_t;

  typedef struct packed {
    logic capture;      // latch input word, clear scan candidates
    logic arrive;       // handle an arrival
    logic clear_active; // completion with empty queue
    logic scan_rd;      // read next entry for the pick scan
    logic pick_rd;      // read the chosen entry
    logic load_active;  // chosen entry goes into service
    logic shift_rd;     // compaction read
    logic shift_end;    // compaction done, drop one from count
    logic load_out;     // load output register
  } cmd_t;

  typedef struct packed {
    logic is_arrival;
    logic queue_empty;
    logic scan_last;
    logic shift_more;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/dsched_ram.sv
// ----------------------------------------------------------------------------
// dsched_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dsched_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/dsched_ctrl.sv
// ----------------------------------------------------------------------------
// dsched_ctrl
// Sequencer: arrival, pick scan, fetch, compaction and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module dsched_ctrl
  import dsched_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_SCAN_END, S_PICK, S_FETCH, S_SHIFT, S_RESULT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:   cmd_o.capture = in_valid_i;
      S_EXEC: begin
        cmd_o.arrive       = sts_i.is_arrival;
        cmd_o.clear_active = !sts_i.is_arrival && sts_i.queue_empty;
      end
      S_SCAN:   cmd_o.scan_rd = 1'b1;
      S_PICK:   cmd_o.pick_rd = 1'b1;
      S_FETCH:  cmd_o.load_active = 1'b1;
      S_SHIFT: begin
        cmd_o.shift_rd  = sts_i.shift_more;
        cmd_o.shift_end = !sts_i.shift_more;
      end
      S_RESULT: cmd_o.load_out = out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (sts_i.is_arrival || sts_i.queue_empty) begin
            state_q <= S_RESULT;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts_i.scan_last) state_q <= S_SCAN_END;
        end
        S_SCAN_END: state_q <= S_PICK;
        S_PICK:     state_q <= S_FETCH;
        S_FETCH:    state_q <= S_SHIFT;
        S_SHIFT: begin
          if (!sts_i.shift_more) state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dsched_dp.sv
// ----------------------------------------------------------------------------
// dsched_dp
// Queue RAM, pick candidates, in-service request and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "disk_request_scheduler_defines.svh"

module dsched_dp
  import dsched_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       cmd_i,
  output sts_t            sts_o,
  input  wire logic [1:0] policy_i,
  input  wire req_t       req_i,
  output res_t            res_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = $bits(entry_t);

  req_t          req_q;
  entry_t        act_q;
  logic          act_valid_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] ptr_q;
  logic          dropped_q;
  res_t          res_q;

  logic          scan_vq_q, shift_vq_q;
  logic [AW-1:0] sidx_q, widx_q;

  // pick candidates: primary (FCFS / SSTF / LOOK same cylinder), ahead, behind
  logic          have_p_q, have_f_q, have_b_q;
  logic [AW-1:0] idx_p_q, idx_f_q, idx_b_q;
  logic [31:0]   arr_p_q;
  logic [15:0]   dist_p_q, dist_f_q, dist_b_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  entry_t        rd_e, req_e;

  logic          full, arrive_wr;
  logic [15:0]   rd_dist;
  logic          same_cyl, ahead;
  logic          upd_p, upd_f, upd_b;
  logic [AW-1:0] pick_idx;
  logic [31:0]   count_ext;

  assign rd_e  = entry_t'(ram_rdata);
  assign req_e = '{id: req_q.req_id, arrival: req_q.req_arrival,
                   cylinder: req_q.req_cylinder, address: req_q.req_address,
                   process: req_q.req_process};

  assign full      = (count_q == CW'(QUEUE_DEPTH));
  assign arrive_wr = cmd_i.arrive && act_valid_q && !full;

  // compaction write lands in the cycle after its read
  assign ram_we    = arrive_wr || shift_vq_q;
  assign ram_waddr = shift_vq_q ? widx_q : count_q[AW-1:0];
  assign ram_wdata = shift_vq_q ? ram_rdata : EW'(req_e);
  assign ram_raddr = cmd_i.pick_rd ? pick_idx : ptr_q[AW-1:0];

  dsched_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    rd_dist  = (req_q.head_cylinder >= rd_e.cylinder) ?
               (req_q.head_cylinder - rd_e.cylinder) :
               (rd_e.cylinder - req_q.head_cylinder);
    same_cyl = (rd_e.cylinder == req_q.head_cylinder);
    ahead    = req_q.scan_up ? (rd_e.cylinder > req_q.head_cylinder) :
                               (rd_e.cylinder < req_q.head_cylinder);
    upd_f    = 1'b0;
    upd_b    = 1'b0;
    case (policy_i)
      POL_SSTF: upd_p = !have_p_q || (rd_dist < dist_p_q) ||
                        ((rd_dist == dist_p_q) && (rd_e.arrival < arr_p_q));
      POL_LOOK: begin
        upd_p = same_cyl && (!have_p_q || (rd_e.arrival < arr_p_q));
        upd_f = !same_cyl && ahead && (!have_f_q || (rd_dist < dist_f_q));
        upd_b = !same_cyl && !ahead && (!have_b_q || (rd_dist < dist_b_q));
      end
      default:  upd_p = !have_p_q || (rd_e.arrival < arr_p_q);
    endcase
    upd_p = upd_p && scan_vq_q;
    upd_f = upd_f && scan_vq_q;
    upd_b = upd_b && scan_vq_q;
  end

  assign pick_idx = have_p_q ? idx_p_q : (have_f_q ? idx_f_q : idx_b_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
    if (upd_p) begin
      idx_p_q  <= sidx_q;
      arr_p_q  <= rd_e.arrival;
      dist_p_q <= rd_dist;
    end
    if (upd_f) begin
      idx_f_q  <= sidx_q;
      dist_f_q <= rd_dist;
    end
    if (upd_b) begin
      idx_b_q  <= sidx_q;
      dist_b_q <= rd_dist;
    end
    sidx_q <= ptr_q[AW-1:0];
    widx_q <= ptr_q[AW-1:0] - AW'(1);
    if (cmd_i.load_out) begin
      res_q.busy_res       <= act_valid_q;
      res_q.serve_id       <= act_q.id;
      res_q.serve_arrival  <= act_q.arrival;
      res_q.serve_cylinder <= act_q.cylinder;
      res_q.serve_address  <= act_q.address;
      res_q.serve_process  <= act_q.process;
      res_q.dropped        <= dropped_q;
      res_q.pending        <= count_ext[4:0];
    end
  end

  assign count_ext = 32'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_valid_q <= 1'b0;
      act_q       <= '0;
      count_q     <= '0;
      ptr_q       <= '0;
      dropped_q   <= 1'b0;
      scan_vq_q   <= 1'b0;
      shift_vq_q  <= 1'b0;
      have_p_q    <= 1'b0;
      have_f_q    <= 1'b0;
      have_b_q    <= 1'b0;
    end else begin
      scan_vq_q  <= cmd_i.scan_rd;
      shift_vq_q <= cmd_i.shift_rd;
      if (cmd_i.capture) begin
        ptr_q     <= '0;
        dropped_q <= 1'b0;
        have_p_q  <= 1'b0;
        have_f_q  <= 1'b0;
        have_b_q  <= 1'b0;
      end else begin
        if (upd_p) have_p_q <= 1'b1;
        if (upd_f) have_f_q <= 1'b1;
        if (upd_b) have_b_q <= 1'b1;
      end
      if (cmd_i.scan_rd || cmd_i.shift_rd) ptr_q <= ptr_q + CW'(1);
      if (cmd_i.pick_rd) ptr_q <= CW'(pick_idx) + CW'(1);
      if (cmd_i.arrive) begin
        if (!act_valid_q) begin
          act_valid_q <= 1'b1;
          act_q       <= req_e;
        end else if (full) begin
          dropped_q <= 1'b1;
        end
      end
      if (arrive_wr) count_q <= count_q + CW'(1);
      if (cmd_i.shift_end) count_q <= count_q - CW'(1);
      if (cmd_i.clear_active) begin
        act_valid_q <= 1'b0;
        act_q       <= '0;
      end
      if (cmd_i.load_active) begin
        act_valid_q <= 1'b1;
        act_q       <= rd_e;
      end
    end
  end

  assign sts_o.is_arrival  = (req_q.req_type == REQ_ARRIVAL);
  assign sts_o.queue_empty = (count_q == '0);
  assign sts_o.scan_last   = (ptr_q == count_q - CW'(1));
  assign sts_o.shift_more  = (ptr_q < count_q);
  assign res_o             = res_q;

  `DRS_ASSERT(a_count_bound, count_q <= CW'(QUEUE_DEPTH), "queue count over depth")
  `DRS_ASSERT_IMP(a_shift_nonempty, cmd_i.shift_end, count_q != '0, "removal from empty queue")
  `DRS_ASSERT_IMP(a_one_writer, shift_vq_q, !cmd_i.arrive, "arrival during compaction")
  `DRS_ASSERT_IMP(a_pick_in_range, cmd_i.pick_rd, CW'(pick_idx) < count_q, "pick past queue end")

endmodule

`default_nettype wire

FILE: rtl/disk_request_scheduler.sv
// Sequence: an arrival, or a completion with an empty queue, goes from capture
//   straight to its result word; a completion with queued entries first scans
//   every entry to pick one, fetches it, then compacts the entries behind it.
// Only one word is in flight at a time; in_stall_o stays high until its result is loaded.
// Reset: async active low; idle, empty queue, policy FCFS. No RAM clearing pass.
// ----------------------------------------------------------------------------
// disk_request_scheduler
// Pending-request queue with FCFS, SSTF or LOOK pick on each completion.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_request_scheduler
  import dsched_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB-style config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // request words
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire req_t        in_data_i,
  // result words
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output res_t             out_data_o
);

  logic [1:0] policy_q;
  logic       reg_hit;
  cmd_t       cmd;
  sts_t       sts;

  // register index is paddr / 4; only the policy register exists
  assign reg_hit = (32'(paddr[2]) == REG_POLICY);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {30'd0, policy_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FCFS;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      policy_q <= pwdata[1:0];
    end
  end

  // sequencer
  dsched_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // queue, pick logic and result register
  dsched_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .policy_i (policy_q),
    .req_i    (in_data_i),
    .res_o    (out_data_o)
  );

endmodule

`default_nettype wire
